// ===== design/cbam_pkg.sv =====
// shared constants and helpers for the cartridge bus address map
package cbam_pkg;

  localparam int AddrW    = 24;
  localparam int ModeW    = 3;
  localparam int SlotW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_MODE       = 3'd0,
    CFG_ROM_SIZE       = 3'd1,
    CFG_SLOT_BASE_0    = 3'd2,
    CFG_SLOT_BASE_1    = 3'd3,
    CFG_SLOT_BASE_2    = 3'd4,
    CFG_SLOT_BASE_3    = 3'd5,
    CFG_REVERSE_LINEAR = 3'd6
  } cfg_reg_t;

  // map modes; codes above MAP_UNKNOWN behave as unknown
  localparam logic [ModeW-1:0] MAP_LOROM       = 3'd0;
  localparam logic [ModeW-1:0] MAP_HIROM       = 3'd1;
  localparam logic [ModeW-1:0] MAP_EXT_LOROM   = 3'd2;
  localparam logic [ModeW-1:0] MAP_EXT_HIROM   = 3'd3;
  localparam logic [ModeW-1:0] MAP_SLOT_BANKED = 3'd4;
  localparam logic [ModeW-1:0] MAP_UNKNOWN     = 3'd5;

  // transaction commands
  localparam logic CMD_BUS_TO_ROM = 1'b0;
  localparam logic CMD_ROM_TO_BUS = 1'b1;

  // reset values
  localparam logic [AddrW-1:0] ROM_SIZE_RST    = 24'h000000;
  localparam logic [SlotW-1:0] SLOT_BASE_0_RST = 8'h00;
  localparam logic [SlotW-1:0] SLOT_BASE_1_RST = 8'h10;
  localparam logic [SlotW-1:0] SLOT_BASE_2_RST = 8'h20;
  localparam logic [SlotW-1:0] SLOT_BASE_3_RST = 8'h30;

  // range limits
  localparam logic [21:0]      EXT_HI_LOW_LIMIT = 22'h3e0000;
  localparam logic [AddrW-1:0] LOROM_ROM_LIMIT  = 24'h400000;
  localparam logic [AddrW-1:0] EXT_LO_ROM_LIMIT = 24'h7f0000;
  localparam logic [AddrW-1:0] EXT_HI_ROM_LIMIT = 24'h7e0000;
  localparam logic [AddrW-1:0] SLOT_ROM_LIMIT   = 24'h800000;
  localparam logic [SlotW:0]   SLOT_SPAN        = 9'd16;

  // fixed bank of each slot's window in the windowed reverse map
  function automatic logic [SlotW-1:0] slot_window(input logic [1:0] slot);
    logic [SlotW-1:0] bank;
    case (slot)
      2'd0:    bank = 8'h00;
      2'd1:    bank = 8'h20;
      2'd2:    bank = 8'h80;
      default: bank = 8'ha0;
    endcase
    return bank;
  endfunction

endpackage

// ===== design/cartridge_bus_address_map.sv =====
// cartridge bus address map: bus address to rom offset and back, one per cycle unless stalled
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_command,         | in
//          | in_address_in                           |
//  out     | out_valid, out_stall, out_address_out,  | out
//          | out_valid_res                           |
//  cfg     | cfg_valid, cfg_ready, cfg_index,        | in
//          | cfg_data                                |
//
// one transaction per cycle while out_stall is low; an input register and a
// result register with the translation logic in between
// reset is synchronous on rst_n and restores all map registers
// a stalled result holds the output register; the input register still takes
// a transaction while the result register waits, so in_stall rises only when
// both are full and out_stall is high
// cfg_ready is always high
module cartridge_bus_address_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [cbam_pkg::AddrW-1:0]      in_address_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cbam_pkg::AddrW-1:0]      out_address_out,
  output logic                            out_valid_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbam_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cbam_pkg::CfgDataW-1:0]   cfg_data
);

  // configuration
  logic [cbam_pkg::ModeW-1:0] map_mode_r;
  logic [cbam_pkg::AddrW-1:0] rom_size_r;
  logic [cbam_pkg::SlotW-1:0] slot_base_0_r;
  logic [cbam_pkg::SlotW-1:0] slot_base_1_r;
  logic [cbam_pkg::SlotW-1:0] slot_base_2_r;
  logic [cbam_pkg::SlotW-1:0] slot_base_3_r;
  logic                       rev_linear_r;

  // input stage
  logic                       s1_valid_r;
  logic                       s1_cmd_r;
  logic [cbam_pkg::AddrW-1:0] s1_addr_r;

  // result stage
  logic                       out_valid_r;
  logic [cbam_pkg::AddrW-1:0] out_addr_r;
  logic                       out_ok_r;
  logic [cbam_pkg::AddrW-1:0] out_addr_nxt;
  logic                       out_ok_nxt;

  logic s1_adv;
  logic in_acc;

  logic [cbam_pkg::SlotW-1:0] bnk;
  logic [1:0]                 fwd_slot;
  logic [cbam_pkg::SlotW-1:0] fwd_base;
  logic [cbam_pkg::AddrW:0]   fwd_pca;
  logic                       fwd_ok;
  logic [3:0]                 slot_hit;
  logic [1:0]                 rev_slot;
  logic [cbam_pkg::SlotW-1:0] rev_base;
  logic [cbam_pkg::AddrW-1:0] rev_res;
  logic                       rev_ok;

  function automatic logic [cbam_pkg::SlotW-1:0] pick_base(
    input logic [1:0]                 slot,
    input logic [cbam_pkg::SlotW-1:0] b0,
    input logic [cbam_pkg::SlotW-1:0] b1,
    input logic [cbam_pkg::SlotW-1:0] b2,
    input logic [cbam_pkg::SlotW-1:0] b3
  );
    logic [cbam_pkg::SlotW-1:0] base;
    case (slot)
      2'd0:    base = b0;
      2'd1:    base = b1;
      2'd2:    base = b2;
      default: base = b3;
    endcase
    return base;
  endfunction

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_valid_res   = out_ok_r;

  assign bnk = s1_addr_r[23:16];

  // high banks pick the slot by bits 5:4, low windows by bits 7 and 5
  assign fwd_slot = (bnk >= 8'hc0) ? bnk[5:4] : {bnk[7], bnk[5]};
  assign fwd_base = pick_base(fwd_slot, slot_base_0_r, slot_base_1_r,
                              slot_base_2_r, slot_base_3_r);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [cbam_pkg::SlotW-1:0] b;
      b = pick_base(2'(i), slot_base_0_r, slot_base_1_r, slot_base_2_r, slot_base_3_r);
      slot_hit[i] = ({1'b0, b} <= {1'b0, bnk}) &&
                    (({1'b0, b} + cbam_pkg::SLOT_SPAN) > {1'b0, bnk});
    end
  end

  // lowest matching slot wins
  always_comb begin
    rev_slot = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (slot_hit[i]) begin
        rev_slot = 2'(i);
      end
    end
  end

  assign rev_base = pick_base(rev_slot, slot_base_0_r, slot_base_1_r,
                              slot_base_2_r, slot_base_3_r);

  // bus address to rom offset
  always_comb begin
    logic [cbam_pkg::AddrW-1:0] a;
    logic                       cond;
    logic [8:0]                 hi_bank;
    a       = s1_addr_r;
    cond    = 1'b0;
    fwd_pca = '0;
    hi_bank = {1'b0, fwd_base} + {5'b0, bnk[3:0]};
    case (map_mode_r)
      cbam_pkg::MAP_LOROM: begin
        cond    = a[15];
        fwd_pca = {3'b0, a[22:16], a[14:0]};
      end
      cbam_pkg::MAP_HIROM: begin
        cond    = 1'b1;
        fwd_pca = {3'b0, a[21:0]};
      end
      cbam_pkg::MAP_EXT_LOROM: begin
        cond    = a[15];
        fwd_pca = {2'b0, ~a[23], a[22:16], a[14:0]};
      end
      cbam_pkg::MAP_EXT_HIROM: begin
        if (a[23]) begin
          cond    = a[22];
          fwd_pca = {3'b0, a[21:0]};
        end else begin
          cond    = a[22] && (a[21:0] < cbam_pkg::EXT_HI_LOW_LIMIT);
          fwd_pca = {2'b0, 1'b1, a[21:0]};
        end
      end
      cbam_pkg::MAP_SLOT_BANKED: begin
        if (bnk >= 8'hc0) begin
          cond    = 1'b1;
          fwd_pca = {hi_bank, a[15:0]};
        end else if (bnk[7:6] != 2'b01) begin
          cond    = a[15];
          fwd_pca = {1'b0, fwd_base, 16'h0000} + {5'b0, bnk[4:0], a[14:0]};
        end
      end
      default: begin
        cond = 1'b0;
      end
    endcase
    fwd_ok = cond && (fwd_pca < {1'b0, rom_size_r});
  end

  // rom offset to bus address
  always_comb begin
    logic [cbam_pkg::AddrW-1:0] p;
    logic                       cond;
    logic [7:0]                 lin_bank;
    logic [7:0]                 win_bank;
    p        = s1_addr_r;
    cond     = 1'b0;
    rev_res  = '0;
    lin_bank = {1'b0, rev_base[6:0]} + {4'b0, bnk[3:0]};
    win_bank = cbam_pkg::slot_window(rev_slot) + {4'b0, bnk[3:0]} + {7'b0, p[16]};
    case (map_mode_r)
      cbam_pkg::MAP_LOROM: begin
        cond    = p < cbam_pkg::LOROM_ROM_LIMIT;
        rev_res = {1'b1, p[21:15], 1'b1, p[14:0]};
      end
      cbam_pkg::MAP_HIROM: begin
        cond    = p < cbam_pkg::LOROM_ROM_LIMIT;
        rev_res = {2'b11, p[21:0]};
      end
      cbam_pkg::MAP_EXT_LOROM: begin
        cond    = p < cbam_pkg::EXT_LO_ROM_LIMIT;
        rev_res = {~p[22], p[21:15], 1'b1, p[14:0]};
      end
      cbam_pkg::MAP_EXT_HIROM: begin
        cond    = p < cbam_pkg::EXT_HI_ROM_LIMIT;
        rev_res = {~p[22], 1'b1, p[21:0]};
      end
      cbam_pkg::MAP_SLOT_BANKED: begin
        cond = (p < cbam_pkg::SLOT_ROM_LIMIT) && (slot_hit != 4'b0000);
        if (rev_linear_r) begin
          rev_res = {lin_bank, p[15:0]} | 24'hc00000;
        end else begin
          // bit 16 of the offset carries into the window bank
          rev_res = {win_bank, 1'b1, p[14:0]};
        end
      end
      default: begin
        cond = 1'b0;
      end
    endcase
    rev_ok = cond && (p < rom_size_r);
  end

  always_comb begin
    if (s1_cmd_r == cbam_pkg::CMD_ROM_TO_BUS) begin
      out_ok_nxt   = rev_ok;
      out_addr_nxt = rev_ok ? rev_res : '0;
    end else begin
      out_ok_nxt   = fwd_ok;
      out_addr_nxt = fwd_ok ? fwd_pca[cbam_pkg::AddrW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r    <= cbam_pkg::MAP_UNKNOWN;
      rom_size_r    <= cbam_pkg::ROM_SIZE_RST;
      slot_base_0_r <= cbam_pkg::SLOT_BASE_0_RST;
      slot_base_1_r <= cbam_pkg::SLOT_BASE_1_RST;
      slot_base_2_r <= cbam_pkg::SLOT_BASE_2_RST;
      slot_base_3_r <= cbam_pkg::SLOT_BASE_3_RST;
      rev_linear_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbam_pkg::CFG_MAP_MODE:       map_mode_r    <= cfg_data[cbam_pkg::ModeW-1:0];
        cbam_pkg::CFG_ROM_SIZE:       rom_size_r    <= cfg_data[cbam_pkg::AddrW-1:0];
        cbam_pkg::CFG_SLOT_BASE_0:    slot_base_0_r <= cfg_data[cbam_pkg::SlotW-1:0];
        cbam_pkg::CFG_SLOT_BASE_1:    slot_base_1_r <= cfg_data[cbam_pkg::SlotW-1:0];
        cbam_pkg::CFG_SLOT_BASE_2:    slot_base_2_r <= cfg_data[cbam_pkg::SlotW-1:0];
        cbam_pkg::CFG_SLOT_BASE_3:    slot_base_3_r <= cfg_data[cbam_pkg::SlotW-1:0];
        cbam_pkg::CFG_REVERSE_LINEAR: rev_linear_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_address_in;
    end
    if (s1_adv && s1_valid_r) begin
      out_addr_r <= out_addr_nxt;
      out_ok_r   <= out_ok_nxt;
    end
  end

endmodule

// ===== design/cbam_checker.sv =====
// port-level checks for the cartridge bus address map, bound to the top level
module cbam_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [cbam_pkg::AddrW-1:0]      out_address_out,
  input logic                            out_valid_res
);

  // a failed translation always reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_address_out == '0)
  else $error("invalid result with nonzero address");

  // input only backs up when the result register is full and stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
  else $error("input stalled while result side can move");

  // a new result rises only for a transaction that was taken and passed the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
  else $error("result without an accepted transaction");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address_out) &&
      $stable(out_valid_res))
  else $error("stalled result changed");

endmodule

bind cartridge_bus_address_map cbam_checker u_cbam_checker (.*);
